/* src/gsm_pkg.sv */
// Package for the sparse matrix-vector engine: payload types, codes and helpers.
`default_nettype none
package gsm_pkg;

  localparam int unsigned NUM_NODES_DEF = 4096;
  localparam int unsigned IDX_W         = 12;
  localparam int unsigned DEG_W         = 13;
  localparam int unsigned VAL_W         = 32;
  localparam int unsigned QDEPTH        = 2;
  localparam logic [31:0] ONE_Q16       = 32'h0001_0000;

  // Input beat
  typedef struct packed {
    logic [1:0]              func;
    logic [IDX_W-1:0]        index;
    logic [IDX_W-1:0]        neighbor;
    logic [DEG_W-1:0]        degree;
    logic signed [VAL_W-1:0] value;
    logic                    last;
    logic                    empty_row;
  } gsm_in_t;

  // Result beat
  typedef struct packed {
    logic [IDX_W-1:0]        out_index;
    logic signed [VAL_W-1:0] out_value;
  } gsm_out_t;

  typedef enum logic [1:0] {
    OP_LOADX = 2'd0,
    OP_ZEROY = 2'd1,
    OP_EDGE  = 2'd2,
    OP_READY = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    MODE_MULT    = 3'd0,
    MODE_TMULT   = 3'd1,
    MODE_DIAG    = 3'd2,
    MODE_ROWSUM  = 3'd3,
    MODE_COLSUM  = 3'd4,
    MODE_SMULT   = 3'd5,
    MODE_STMULT  = 3'd6,
    MODE_UNUSED  = 3'd7
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XWAIT,
    S_DIV,
    S_APPLY,
    S_YWAIT,
    S_RDY
  } bstate_e;

  // Classified queue entry
  typedef struct packed {
    op_e     op;
    gsm_in_t item;
  } q_entry_t;

  // Clamp a widened sum to the signed 32-bit range
  function automatic logic [31:0] sat32(input logic signed [33:0] s);
    logic signed [33:0] maxv;
    logic signed [33:0] minv;
    maxv = 34'sh0_7FFF_FFFF;
    minv = -34'sh0_8000_0000;
    if (s > maxv) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (s < minv) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = s[31:0];
    end
  endfunction

endpackage
`default_nettype wire

/* src/graph_sparse_matvec_engine.sv */
// Top level of the sparse matrix-vector engine: mode register, front queue and back end.
//
//  channel  | signals                          | direction
//  ---------+----------------------------------+----------
//  input    | start, item_i (busy is out)      | in
//  result   | out_valid_o, result_o            | out
//  config   | cfg_we_i, cfg_wdata_i            | in
//
// Load x, zero y: written from idle. Read y: read in idle; the result beat is registered
// in the ready state. Edge: x read, then apply; column modes add a y read-modify-write,
// divide modes the bit-serial divider. A two-entry queue takes beats while the back end
// works; busy is high while it is full. Reset clears control only; x and y hold garbage
// until written. Result beats are strobed for one cycle and cannot be stalled.
`default_nettype none
module graph_sparse_matvec_engine #(
  parameter int unsigned NUM_NODES = gsm_pkg::NUM_NODES_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire gsm_pkg::gsm_in_t item_i,
  output logic                  out_valid_o,
  output gsm_pkg::gsm_out_t     result_o,
  input  wire logic             cfg_we_i,
  input  wire logic [2:0]       cfg_wdata_i
);
  import gsm_pkg::*;

  mode_e    mode_q;
  q_entry_t head;
  logic     head_valid, pop;

  // Mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MULT;
    end else if (cfg_we_i) begin
      mode_q <= mode_e'(cfg_wdata_i);
    end
  end

  gsm_front u_front (
    .clk_i, .rst_ni, .start, .busy, .item_i,
    .head_o(head), .head_valid_o(head_valid), .pop_i(pop)
  );

  gsm_back #(.NUM_NODES(NUM_NODES)) u_back (
    .clk_i, .rst_ni, .mode_i(mode_q), .head_i(head), .head_valid_i(head_valid),
    .pop_o(pop), .out_valid_o, .result_o
  );

endmodule
`default_nettype wire

/* src/gsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* src/gsm_front.sv */
// Front end: classifies incoming beats and queues them for the back end.
`default_nettype none
module gsm_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire gsm_pkg::gsm_in_t   item_i,
  output gsm_pkg::q_entry_t       head_o,
  output logic                    head_valid_o,
  input  wire logic               pop_i
);
  import gsm_pkg::*;

  q_entry_t   ent_q [QDEPTH];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy         = (cnt_q == 2'(QDEPTH));
  assign push         = start && !busy;
  assign head_o       = ent_q[rptr_q];
  assign head_valid_o = (cnt_q != 2'd0);

  // Queue storage, op decoded on entry
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wptr_q].op   <= op_e'(item_i.func);
      ent_q[wptr_q].item <= item_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop_i) rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

/* src/gsm_div.sv */
// Bit-serial signed divider: 32-bit dividend by a nonzero 13-bit divisor, truncating.
`default_nettype none
module gsm_div (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [31:0] dividend_i,
  input  wire logic [12:0]        divisor_i,
  output logic                    done_o,
  output logic signed [32:0]      quot_o
);

  logic        busy_q, done_q, neg_q;
  logic [4:0]  cnt_q;
  logic [12:0] rem_q, dvs_q;
  logic [31:0] quo_q;
  logic [13:0] sh, diff;
  logic        ge;

  // One quotient bit per cycle
  assign sh   = {rem_q, quo_q[31]};
  assign diff = sh - {1'b0, dvs_q};
  assign ge   = (sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i[31] ? (32'd0 - dividend_i) : dividend_i;
      rem_q <= 13'd0;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[31];
    end else if (busy_q) begin
      rem_q <= ge ? diff[12:0] : sh[12:0];
      quo_q <= {quo_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd31;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? (33'sd0 - $signed({1'b0, quo_q})) : $signed({1'b0, quo_q});

endmodule
`default_nettype wire

/* src/gsm_back.sv */
// Back end: executes queued beats against the x and y stores.
`default_nettype none
module gsm_back #(
  parameter int unsigned NUM_NODES = gsm_pkg::NUM_NODES_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gsm_pkg::mode_e    mode_i,
  input  wire gsm_pkg::q_entry_t head_i,
  input  wire logic              head_valid_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  output gsm_pkg::gsm_out_t      result_o
);
  import gsm_pkg::*;

  localparam int unsigned AW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;

  function automatic logic in_rng(input logic [IDX_W-1:0] i);
    in_rng = (32'(i) < NUM_NODES);
  endfunction

  bstate_e            state_q, state_d;
  gsm_in_t            item_q, item_d;
  logic signed [32:0] term_q, term_d;
  logic signed [31:0] acc_q, acc_d, acc_new;
  logic               seen_q, seen_d, seen_new;
  logic               xok_q, xok_d;
  gsm_out_t           out_q, out_d;
  logic               outv_q, outv_d;

  logic          x_we, y_we, div_start, div_done, row_end;
  logic [AW-1:0] x_wa, x_ra, y_wa, y_ra;
  logic [31:0]   x_wd, y_wd, x_rd, y_rd, xval;
  logic signed [32:0] div_q;

  gsm_ram #(.WIDTH(VAL_W), .DEPTH(NUM_NODES)) u_xram (
    .clk_i, .we_i(x_we), .waddr_i(x_wa), .wdata_i(x_wd), .raddr_i(x_ra), .rdata_o(x_rd)
  );
  gsm_ram #(.WIDTH(VAL_W), .DEPTH(NUM_NODES)) u_yram (
    .clk_i, .we_i(y_we), .waddr_i(y_wa), .wdata_i(y_wd), .raddr_i(y_ra), .rdata_o(y_rd)
  );

  assign xval = xok_q ? x_rd : 32'd0;

  gsm_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i($signed(xval)),
    .divisor_i(item_q.degree), .done_o(div_done), .quot_o(div_q)
  );

  assign row_end = item_q.last || item_q.empty_row;

  // Sequencer: next state, store ports and datapath updates
  always_comb begin
    state_d   = state_q;
    item_d    = item_q;
    term_d    = term_q;
    acc_d     = acc_q;
    seen_d    = seen_q;
    xok_d     = xok_q;
    out_d     = out_q;
    outv_d    = 1'b0;
    pop_o     = 1'b0;
    div_start = 1'b0;
    x_we      = 1'b0;
    x_wa      = AW'(head_i.item.index);
    x_wd      = head_i.item.value;
    x_ra      = AW'(head_i.item.neighbor);
    y_we      = 1'b0;
    y_wa      = AW'(item_q.index);
    y_wd      = 32'd0;
    y_ra      = AW'(head_i.item.index);
    acc_new   = acc_q;
    seen_new  = seen_q;
    case (state_q)
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o  = 1'b1;
          item_d = head_i.item;
          case (head_i.op)
            OP_LOADX: x_we = in_rng(head_i.item.index);
            OP_ZEROY: begin
              y_we = in_rng(head_i.item.index);
              y_wa = AW'(head_i.item.index);
            end
            OP_READY: state_d = S_RDY;
            OP_EDGE: begin
              if (mode_i == MODE_TMULT || mode_i == MODE_STMULT) begin
                x_ra  = AW'(head_i.item.index);
                xok_d = in_rng(head_i.item.index);
              end else begin
                xok_d = in_rng(head_i.item.neighbor);
              end
              state_d = S_XWAIT;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_XWAIT: begin
        if (mode_i == MODE_COLSUM) begin
          term_d  = 33'(ONE_Q16);
          state_d = S_APPLY;
        end else if ((mode_i == MODE_SMULT || mode_i == MODE_STMULT) &&
                     !item_q.empty_row && item_q.degree != '0) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          term_d  = 33'($signed(xval));
          state_d = S_APPLY;
        end
      end
      S_DIV: begin
        if (div_done) begin
          term_d  = div_q;
          state_d = S_APPLY;
        end
      end
      S_APPLY: begin
        state_d = S_IDLE;
        if (!item_q.empty_row) begin
          case (mode_i)
            MODE_MULT, MODE_SMULT: acc_new = sat32(34'(acc_q) + 34'(term_q));
            MODE_DIAG: if (item_q.neighbor == item_q.index) seen_new = 1'b1;
            MODE_TMULT, MODE_COLSUM, MODE_STMULT: begin
              y_ra    = AW'(item_q.neighbor);
              state_d = S_YWAIT;
            end
            default: acc_new = acc_q;
          endcase
        end
        acc_d  = acc_new;
        seen_d = seen_new;
        // Row close-out
        if (row_end) begin
          acc_d  = '0;
          seen_d = 1'b0;
          case (mode_i)
            MODE_MULT, MODE_SMULT: begin
              y_we = in_rng(item_q.index);
              y_wd = acc_new;
            end
            MODE_DIAG: begin
              y_we = in_rng(item_q.index);
              y_wd = seen_new ? ONE_Q16 : 32'd0;
            end
            MODE_ROWSUM: begin
              y_we = in_rng(item_q.index);
              y_wd = {3'd0, item_q.degree, 16'd0};
            end
            default: y_we = 1'b0;
          endcase
        end
      end
      S_YWAIT: begin
        y_we    = in_rng(item_q.neighbor);
        y_wa    = AW'(item_q.neighbor);
        y_wd    = sat32(34'($signed(y_rd)) + 34'(term_q));
        state_d = S_IDLE;
      end
      S_RDY: begin
        out_d.out_index = item_q.index;
        out_d.out_value = in_rng(item_q.index) ? y_rd : 32'd0;
        outv_d          = 1'b1;
        state_d         = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
      seen_q  <= 1'b0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      outv_q  <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    term_q <= term_d;
    xok_q  <= xok_d;
    out_q  <= out_d;
  end

  assign out_valid_o = outv_q;
  assign result_o    = out_q;

`ifndef SYNTHESIS
  a_out_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outv_q |-> $past(state_q == S_RDY))
    else $error("result beat without a y read");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside divide state");
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q != S_IDLE || $past(head_i.op == OP_LOADX || head_i.op == OP_ZEROY)))
    else $error("popped beat was not taken up");
`endif

endmodule
`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the sparse matrix-vector engine.
module testbench;
  import gsm_pkg::*;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  gsm_in_t  item_i;
  logic     out_valid_o;
  gsm_out_t result_o;
  logic     cfg_we_i;
  logic [2:0] cfg_wdata_i;

  graph_sparse_matvec_engine DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .out_valid_o(out_valid_o), .result_o(result_o),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i)
  );

  // Predictor state
  logic signed [31:0] x_mem [NUM_NODES_DEF];
  logic signed [31:0] y_mem [NUM_NODES_DEF];
  logic signed [31:0] acc_q;
  logic               diag_q;
  mode_e              mode_q;

  gsm_in_t  pending_beats [$];
  gsm_out_t expected_reads [$];
  int  errors;
  int  accepted;
  int  queued;
  int  gap_cnt;
  longint cycles;
  logic busy_at_edge;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic signed [31:0] sat_sum(logic signed [31:0] a,
                                                 logic signed [31:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    if (s > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (s < -34'sh0_8000_0000) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  function automatic logic signed [31:0] scale_by_degree(logic signed [31:0] v,
                                                         logic [12:0] d);
    longint q;
    if (d == 0) return v;
    q = longint'(v) / longint'({19'd0, d});
    return q[31:0];
  endfunction

  // Advance the predictor by one accepted beat
  task automatic predict_beat(gsm_in_t b);
    gsm_out_t o;
    logic is_last;
    case (op_e'(b.func))
      OP_LOADX: x_mem[b.index] = b.value;
      OP_ZEROY: y_mem[b.index] = 0;
      OP_READY: begin
        o.out_index = b.index;
        o.out_value = y_mem[b.index];
        expected_reads.push_back(o);
      end
      default: begin
        is_last = b.last | b.empty_row;
        if (!b.empty_row) begin
          case (mode_q)
            MODE_MULT:   acc_q = sat_sum(acc_q, x_mem[b.neighbor]);
            MODE_TMULT:  y_mem[b.neighbor] = sat_sum(y_mem[b.neighbor], x_mem[b.index]);
            MODE_DIAG:   if (b.neighbor == b.index) diag_q = 1'b1;
            MODE_COLSUM: y_mem[b.neighbor] = sat_sum(y_mem[b.neighbor], ONE_Q16);
            MODE_SMULT:  acc_q = sat_sum(acc_q, scale_by_degree(x_mem[b.neighbor], b.degree));
            MODE_STMULT: y_mem[b.neighbor] = sat_sum(y_mem[b.neighbor],
                                             scale_by_degree(x_mem[b.index], b.degree));
            default: ;
          endcase
        end
        if (is_last) begin
          case (mode_q)
            MODE_MULT, MODE_SMULT: y_mem[b.index] = acc_q;
            MODE_DIAG:   y_mem[b.index] = diag_q ? ONE_Q16 : 32'sd0;
            MODE_ROWSUM: y_mem[b.index] = {3'd0, b.degree, 16'd0};
            default: ;
          endcase
          acc_q  = 0;
          diag_q = 1'b0;
        end
      end
    endcase
  endtask

  // Driver: one beat at a time, random gap before each
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !busy_at_edge) begin
      // previous beat was taken at the last rising edge
      if (pending_beats.size() > 0 && gap_cnt == 0) begin
        item_i <= pending_beats.pop_front();
        gap_cnt <= $urandom_range(0, 4);
      end else begin
        start <= 1'b0;
      end
    end else if (!start) begin
      if (gap_cnt > 0) begin
        gap_cnt <= gap_cnt - 1;
      end else if (pending_beats.size() > 0) begin
        item_i <= pending_beats.pop_front();
        start <= 1'b1;
        gap_cnt <= $urandom_range(0, 4);
      end
    end
  end

  // Handshake and result checking at the rising edge
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    busy_at_edge <= busy;
    if (rst_ni && start && !busy) begin
      predict_beat(item_i);
      accepted <= accepted + 1;
    end
    if (rst_ni && out_valid_o) begin
      if (expected_reads.size() == 0) begin
        $error("unexpected result beat index %0d", result_o.out_index);
        errors++;
      end else begin
        gsm_out_t e;
        e = expected_reads.pop_front();
        if (e.out_index !== result_o.out_index) begin
          $error("out_index expected %0d actual %0d", e.out_index, result_o.out_index);
          errors++;
        end
        if (e.out_value !== result_o.out_value) begin
          $error("out_value expected %0h actual %0h", e.out_value, result_o.out_value);
          errors++;
        end
      end
    end
  end

  // Build a beat
  function automatic gsm_in_t mk(op_e f, int idx, int nb, int deg, logic [31:0] v,
                                 bit lst, bit emp);
    gsm_in_t b;
    b.func = f;  b.index = idx[11:0];  b.neighbor = nb[11:0];
    b.degree = deg[12:0];  b.value = v;  b.last = lst;  b.empty_row = emp;
    return b;
  endfunction

  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 65536 * 4) - 65536 * 2;
      default: return $urandom;
    endcase
  endfunction

  task automatic push(gsm_in_t b);
    pending_beats.push_back(b);
    queued++;
  endtask

  // Wait until every queued beat is taken and all reads have returned
  task automatic drain();
    while (accepted < queued || expected_reads.size() > 0 || start) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_mode(mode_e m);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= m;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    mode_q = m;
  endtask

  // Node pool used by random graphs; entries loaded before any read
  int base_node;
  int nodes;

  task automatic random_phase(mode_e m, int rows);
    int r, deg, nk;
    set_mode(m);
    base_node = $urandom_range(0, 1) ? 4096 - 16 : $urandom_range(0, 4000);
    nodes = 16;
    for (int i = 0; i < nodes; i++) begin
      push(mk(OP_LOADX, base_node + i, $urandom, $urandom, rand_val(), $urandom, $urandom));
      push(mk(OP_ZEROY, base_node + i, $urandom, $urandom, $urandom, $urandom, $urandom));
    end
    for (int k = 0; k < rows; k++) begin
      r = base_node + $urandom_range(0, nodes - 1);
      nk = $urandom_range(0, 5);
      deg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : nk;
      if (nk == 0) begin
        push(mk(OP_EDGE, r, $urandom, deg, $urandom, 1'b1, 1'b1));
      end else begin
        for (int e = 0; e < nk; e++)
          push(mk(OP_EDGE, r, ($urandom_range(0, 3) == 0) ? r :
                  base_node + $urandom_range(0, nodes - 1), deg, $urandom,
                  e == nk - 1, 1'b0));
      end
      if ($urandom_range(0, 2) == 0)
        push(mk(OP_READY, base_node + $urandom_range(0, nodes - 1), $urandom, $urandom,
                $urandom, $urandom, $urandom));
    end
    for (int i = 0; i < nodes; i++)
      push(mk(OP_READY, base_node + i, $urandom, $urandom, $urandom, $urandom, $urandom));
    drain();
  endtask

  initial begin
    logic [2:0] mraw;
    errors = 0; accepted = 0; queued = 0; gap_cnt = 0; cycles = 0;
    rst_ni = 1'b0; start = 1'b0; item_i = '0; cfg_we_i = 1'b0; cfg_wdata_i = '0;
    busy_at_edge = 1'b0;
    acc_q = 0; diag_q = 1'b0; mode_q = MODE_MULT;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, saturation, zero degree, empty row, self loop
    set_mode(MODE_MULT);
    push(mk(OP_LOADX, 0, 0, 0, 32'h7FFF_FFFF, 0, 0));
    push(mk(OP_LOADX, 4095, 0, 0, 32'h8000_0000, 0, 0));
    push(mk(OP_ZEROY, 0, 0, 0, 0, 0, 0));
    push(mk(OP_ZEROY, 4095, 0, 0, 0, 0, 0));
    push(mk(OP_EDGE, 0, 0, 2, 0, 0, 0));
    push(mk(OP_EDGE, 0, 0, 2, 0, 1, 0));
    push(mk(OP_EDGE, 4095, 4095, 2, 0, 0, 0));
    push(mk(OP_EDGE, 4095, 4095, 2, 0, 1, 0));
    push(mk(OP_READY, 0, 0, 0, 0, 0, 0));
    push(mk(OP_READY, 4095, 0, 0, 0, 0, 0));
    drain();
    set_mode(MODE_ROWSUM);
    push(mk(OP_EDGE, 0, 4095, 4096, 0, 1, 1));
    push(mk(OP_EDGE, 4095, 0, 8191, 0, 1, 0));
    push(mk(OP_READY, 0, 0, 0, 0, 0, 0));
    push(mk(OP_READY, 4095, 0, 0, 0, 0, 0));
    drain();
    set_mode(MODE_STMULT);
    push(mk(OP_EDGE, 0, 4095, 0, 0, 1, 0));
    push(mk(OP_EDGE, 4095, 0, 3, 0, 1, 0));
    push(mk(OP_READY, 4095, 0, 0, 0, 0, 0));
    push(mk(OP_READY, 0, 0, 0, 0, 0, 0));
    drain();
    set_mode(MODE_UNUSED);
    push(mk(OP_EDGE, 0, 0, 1, 0, 1, 0));
    push(mk(OP_READY, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases through every mode, extremes included
    for (int p = 0; p < 16; p++) begin
      mraw = (p < 8) ? p[2:0] : 3'($urandom_range(0, 7));
      random_phase(mode_e'(mraw), 18);
    end
    drain();
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Run limit
  always @(posedge clk_i) begin
    if (cycles > 400000) begin
      $display("testbench failed");
      $finish;
    end
  end

endmodule

/* sim.f */
src/gsm_pkg.sv
src/gsm_ram.sv
src/gsm_front.sv
src/gsm_div.sv
src/gsm_back.sv
src/graph_sparse_matvec_engine.sv
sim/testbench.sv
